@@ rtl/core/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants of the point in polygon test
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  localparam int FIELD_BITS = 32;
  localparam int INDEX_BITS = 4;
  localparam int COUNT_BITS = 5;
  localparam int EDGE_LAT   = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(4);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TEST  = 1'b1
  } pip_op_t;

  typedef struct packed {
    logic load;
    logic edge_en;
    logic close;
  } pip_step_t;

endpackage

`default_nettype wire

@@ rtl/core/pip_in_if.sv @@
// ----------------------------------------------------------------------------
// pip_in_if
// input channel: vertex write or point test item
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_in_if;
  import pip_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [INDEX_BITS-1:0]        vertex_index;
  logic signed [FIELD_BITS-1:0] coord_x;
  logic signed [FIELD_BITS-1:0] coord_y;

  modport source (output valid, output operation, output vertex_index,
                  output coord_x, output coord_y, input ready);
  modport sink   (input valid, input operation, input vertex_index,
                  input coord_x, input coord_y, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pip_out_if.sv @@
// ----------------------------------------------------------------------------
// pip_out_if
// result channel: inside flag of one test
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pip_vertex_cell.sv @@
// ----------------------------------------------------------------------------
// pip_vertex_cell
// one ring cell: holds a vertex, loads it on a matching write, shifts on rotate
// ----------------------------------------------------------------------------
`default_nettype none

module pip_vertex_cell #(
  parameter int INDEX      = 0,
  parameter int COORD_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [pip_pkg::INDEX_BITS-1:0]    wr_idx,
  input  wire logic signed [COORD_BITS-1:0]      wr_x,
  input  wire logic signed [COORD_BITS-1:0]      wr_y,
  input  wire logic                              shift,
  input  wire logic signed [COORD_BITS-1:0]      nb_x,
  input  wire logic signed [COORD_BITS-1:0]      nb_y,
  output logic signed [COORD_BITS-1:0]           x,
  output logic signed [COORD_BITS-1:0]           y
);
  import pip_pkg::*;

  logic signed [COORD_BITS-1:0] x_r, x_nxt;
  logic signed [COORD_BITS-1:0] y_r, y_nxt;
  logic                         hit;

  assign hit = wr_en && (32'(wr_idx) == 32'(INDEX));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (shift) begin
      x_nxt = nb_x;
      y_nxt = nb_y;
    end else if (hit) begin
      x_nxt = wr_x;
      y_nxt = wr_y;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign x = x_r;
  assign y = y_r;

endmodule

`default_nettype wire

@@ rtl/core/pip_edge_unit.sv @@
// ----------------------------------------------------------------------------
// pip_edge_unit
// edge crossing pipeline: differences, cross products, signed compare, flag
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_unit #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clear,
  input  wire pip_pkg::pip_step_t            step,
  input  wire logic signed [COORD_BITS-1:0]  head_x,
  input  wire logic signed [COORD_BITS-1:0]  head_y,
  input  wire logic signed [COORD_BITS-1:0]  pt_x,
  input  wire logic signed [COORD_BITS-1:0]  pt_y,
  output logic                               cross_odd
);
  import pip_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_BITS-1:0] first_x_r, first_y_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;

  logic                 a_valid_r, a_valid_nxt;
  logic                 a_dypos_r;
  logic signed [DW-1:0] a_r, b_r, c_r, dy_r;

  logic                 b_valid_r, b_valid_nxt;
  logic                 b_dypos_r;
  logic signed [PW-1:0] lhs_r, rhs_r;

  logic                 flag_r, flag_nxt;
  logic                 right;

  // closing edge runs back to the first vertex
  assign cur_x = step.close ? first_x_r : head_x;
  assign cur_y = step.close ? first_y_r : head_y;

  assign a_valid_nxt = (step.edge_en || step.close) && ((cur_y > pt_y) != (prev_y_r > pt_y));
  assign b_valid_nxt = a_valid_r;

  assign right = b_dypos_r ? (lhs_r < rhs_r) : (rhs_r < lhs_r);

  always_comb begin
    flag_nxt = flag_r;
    if (clear) begin
      flag_nxt = 1'b0;
    end else if (b_valid_r && right) begin
      flag_nxt = !flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step.load) begin
      first_x_r <= head_x;
      first_y_r <= head_y;
    end
    if (step.load || step.edge_en) begin
      prev_x_r <= head_x;
      prev_y_r <= head_y;
    end
    a_dypos_r <= prev_y_r > cur_y;
    a_r       <= DW'(pt_x) - DW'(cur_x);
    b_r       <= DW'(prev_x_r) - DW'(cur_x);
    c_r       <= DW'(pt_y) - DW'(cur_y);
    dy_r      <= DW'(prev_y_r) - DW'(cur_y);
    b_dypos_r <= a_dypos_r;
    lhs_r     <= PW'(a_r) * PW'(dy_r);
    rhs_r     <= PW'(b_r) * PW'(c_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      flag_r    <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      flag_r    <= flag_nxt;
    end
  end

  assign cross_odd = flag_r;

endmodule

`default_nettype wire

@@ rtl/core/point_in_polygon_test.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test
// even-odd point in polygon test over a ring of vertex cells
// ----------------------------------------------------------------------------
// Vertices live in a ring of MAX_VERTICES cells. A write item loads one cell
// and gives no result. A test item rotates the ring once around, so the head
// cell presents one vertex per cycle to a three-stage edge pipeline
// (differences, two cross products, signed compare); the closing edge back to
// the first vertex takes one more slot. The result is registered once the
// ring has turned and the edge pipeline has drained, and the next item is
// taken once that result has been registered. The vertex count is read from
// cfg_wr_data when cfg_wr_en is high, and is used as at most MAX_VERTICES.
`default_nettype none

module point_in_polygon_test #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pip_in_if.sink                             in_chan,
  pip_out_if.source                          out_chan,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pip_pkg::COUNT_BITS-1:0] cfg_wr_data
);
  import pip_pkg::*;

  localparam int LAST = MAX_VERTICES + EDGE_LAT;
  localparam int CW   = $clog2(LAST + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0]        count_r;
  logic [CW-1:0]                n_used;
  logic signed [COORD_BITS-1:0] pt_x_r, pt_y_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_inside_r, out_inside_nxt;

  logic                         in_take, is_test, wr_en, rotate, out_free, cross_odd;
  logic signed [COORD_BITS-1:0] in_x, in_y;
  pip_step_t                    step;

  logic signed [COORD_BITS-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cell_y [MAX_VERTICES];

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_take       = in_chan.valid && in_chan.ready;
  assign is_test       = (pip_op_t'(in_chan.operation) == OP_TEST);
  assign wr_en         = in_take && !is_test;
  assign in_x          = in_chan.coord_x[COORD_BITS-1:0];
  assign in_y          = in_chan.coord_y[COORD_BITS-1:0];
  assign out_free      = !out_valid_r || out_chan.ready;

  assign n_used = (32'(count_r) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(count_r);

  assign rotate       = (state_r == S_RUN) && (32'(cnt_r) < MAX_VERTICES);
  assign step.load    = (state_r == S_RUN) && (cnt_r == '0);
  assign step.edge_en = (state_r == S_RUN) && (cnt_r != '0) && (cnt_r < n_used);
  assign step.close   = (state_r == S_RUN) && (cnt_r == n_used) && (n_used != '0);

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    localparam int NB = (k + 1) % MAX_VERTICES;
    pip_vertex_cell #(
      .INDEX      (k),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk    (clk),
      .wr_en  (wr_en),
      .wr_idx (in_chan.vertex_index),
      .wr_x   (in_x),
      .wr_y   (in_y),
      .shift  (rotate),
      .nb_x   (cell_x[NB]),
      .nb_y   (cell_y[NB]),
      .x      (cell_x[k]),
      .y      (cell_y[k])
    );
  end

  pip_edge_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (in_take && is_test),
    .step      (step),
    .head_x    (cell_x[0]),
    .head_y    (cell_y[0]),
    .pt_x      (pt_x_r),
    .pt_y      (pt_y_r),
    .cross_odd (cross_odd)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_inside_nxt = out_inside_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_take && is_test) begin
          state_nxt = S_RUN;
          cnt_nxt   = '0;
        end
      end
      S_RUN: begin
        if (cnt_r == CW'(LAST)) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_inside_nxt = cross_odd;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = cross_odd;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      count_r     <= COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
    out_inside_r <= out_inside_nxt;
    if (in_take && is_test) begin
      pt_x_r <= in_x;
      pt_y_r <= in_y;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.inside_res = out_inside_r;

endmodule

`default_nettype wire
